@@ src/ctg_pkg.sv @@
// ----------------------------------------------------------------------------
// ctg_pkg
// Shared types, constants and helpers of the Cayley table group check.
// ----------------------------------------------------------------------------
package ctg_pkg;

  // largest domain the table store can hold
  localparam int MAX_ORDER = 16;

  // fixed field widths
  localparam int VAL_W   = 4;
  localparam int ORD_W   = 5;
  localparam int CFG_W   = ORD_W;
  localparam int CFG_IDX_W = 1;

  // derived widths
  localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W  = $clog2(MAX_ORDER + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP_ORDER = 1'b0,
    CFG_IDENTITY    = 1'b1
  } cfg_reg_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RNG_RD,
    ST_RNG_CHK,
    ST_ID_RD,
    ST_ID_CHK,
    ST_AS_AB_RD,
    ST_AS_AB_WT,
    ST_AS_C_RD,
    ST_AS_C_WT,
    ST_AS_CMP,
    ST_INV_RD,
    ST_INV_CHK,
    ST_DONE
  } state_e;

  // loop counter operations
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_STEP_A,
    CNT_STEP_B,
    CNT_STEP_C
  } cnt_op_e;

  // table read address selection
  typedef enum logic [1:0] {
    RD_AB,
    RD_ID,
    RD_BC,
    RD_A_BC
  } rd_sel_e;

  typedef struct packed {
    cnt_op_e cnt_op;
    rd_sel_e rd_sel;
    logic    flags_init;
    logic    fail_range;
    logic    fail_id;
    logic    fail_as;
    logic    fail_inv;
    logic    ld_ab;
    logic    ld_lhs;
    logic    ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic e_bad;
    logic range_fail;
    logic id_mismatch;
    logic as_mismatch;
    logic inv_hit;
    logic a_last;
    logic b_last;
    logic c_last;
  } dp_sts_t;

  typedef struct packed {
    logic identity_pass;
    logic assoc_pass;
    logic inverse_ok;
    logic range_ok;
  } result_t;

  // table value to row or column index
  function automatic logic [IDX_W-1:0] to_idx(logic [VAL_W-1:0] v);
    return IDX_W'(v);
  endfunction

endpackage

@@ src/ctg_ifs.sv @@
// ----------------------------------------------------------------------------
// ctg_ifs
// Valid/ready channels of the Cayley table group check: table entries in,
// verdicts out.
// ----------------------------------------------------------------------------
interface ctg_entry_if;
  logic                      valid;
  logic                      ready;
  logic [ctg_pkg::VAL_W-1:0] entry_row;
  logic [ctg_pkg::VAL_W-1:0] entry_col;
  logic [ctg_pkg::VAL_W-1:0] entry_value;
  logic                      last_entry;

  modport source (
    output valid, entry_row, entry_col, entry_value, last_entry,
    input  ready
  );
  modport sink (
    input  valid, entry_row, entry_col, entry_value, last_entry,
    output ready
  );
endinterface

interface ctg_result_if;
  logic valid;
  logic ready;
  logic identity_pass;
  logic assoc_pass;
  logic inverse_ok;
  logic range_ok;

  modport source (
    output valid, identity_pass, assoc_pass, inverse_ok, range_ok,
    input  ready
  );
  modport sink (
    input  valid, identity_pass, assoc_pass, inverse_ok, range_ok,
    output ready
  );
endinterface

@@ src/cayley_table_group_check.sv @@
// ----------------------------------------------------------------------------
// cayley_table_group_check
// Loads an operation table over {0..n-1} and checks the group axioms for a
// configured identity element.
// ----------------------------------------------------------------------------
// Table entries (row, column, value) are taken one beat per cycle while the
// block is idle and go straight into a 16x16 table memory; entries with a row
// or column outside the table are dropped, and the table keeps its contents
// between checks. The beat marked last is stored and then starts a check,
// during which the entry channel is held off. The check runs on one table
// memory with two registered read ports and visits the table in order: a
// range sweep (values and the identity must lie below n, else all four
// verdicts are 0 and the sweeps below are skipped), an identity sweep, an
// associativity sweep in which each triple needs a chain of three dependent
// table reads, and an inverse search, after which the verdict is posted.
// Sweeps stop early at their first failure; the worst case of a check is set
// by the associativity read chain. One verdict beat comes out per check, held
// in an output register so that table loading for the next check can go on
// while it waits. group_order (index 0, resets to 1, saturates at 16) and
// identity_element (index 1, resets to 0) are written through the config
// port; the user must write them only while the block is idle, the block
// itself does not enforce it. The table memory has no reset; a check that
// reads an entry that was never written gives undefined verdicts.
// ----------------------------------------------------------------------------
module cayley_table_group_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ctg_entry_if.sink                     entry_i,
  ctg_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [ctg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ctg_pkg::CFG_W-1:0]     cfg_wdata_i
);

  // configuration registers
  logic [ctg_pkg::ORD_W-1:0] order_q;
  logic [ctg_pkg::VAL_W-1:0] ident_q;

  logic             entry_fire;
  logic             in_ready;
  logic             out_valid;
  ctg_pkg::dp_cmd_t cmd;
  ctg_pkg::dp_sts_t sts;
  ctg_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ctg_pkg::ORD_W'(1);
      ident_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ctg_pkg::CFG_GROUP_ORDER: order_q <= cfg_wdata_i[ctg_pkg::ORD_W-1:0];
        ctg_pkg::CFG_IDENTITY:    ident_q <= cfg_wdata_i[ctg_pkg::VAL_W-1:0];
        default: begin
          order_q <= order_q;
        end
      endcase
    end
  end

  // every accepted beat writes the table, last or not
  assign entry_fire    = entry_i.valid && in_ready;
  assign entry_i.ready = in_ready;

  ctg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (entry_i.valid),
    .last_i      (entry_i.last_entry),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ctg_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .order_i  (order_q),
    .ident_i  (ident_q),
    .wr_en_i  (entry_fire),
    .wr_row_i (entry_i.entry_row),
    .wr_col_i (entry_i.entry_col),
    .wr_val_i (entry_i.entry_value),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .res_o    (res)
  );

  // verdict beat
  assign result_o.valid         = out_valid;
  assign result_o.identity_pass = res.identity_pass;
  assign result_o.assoc_pass    = res.assoc_pass;
  assign result_o.inverse_ok    = res.inverse_ok;
  assign result_o.range_ok      = res.range_ok;

endmodule

@@ src/ctg_dp.sv @@
// ----------------------------------------------------------------------------
// ctg_dp
// Datapath: table memory with two registered read ports, loop counters,
// verdict flags and the result register.
// ----------------------------------------------------------------------------
module ctg_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ctg_pkg::ORD_W-1:0] order_i,
  input  logic [ctg_pkg::VAL_W-1:0] ident_i,
  input  logic                      wr_en_i,
  input  logic [ctg_pkg::VAL_W-1:0] wr_row_i,
  input  logic [ctg_pkg::VAL_W-1:0] wr_col_i,
  input  logic [ctg_pkg::VAL_W-1:0] wr_val_i,
  input  ctg_pkg::dp_cmd_t          cmd_i,
  output ctg_pkg::dp_sts_t          sts_o,
  output ctg_pkg::result_t          res_o
);

  logic [ctg_pkg::VAL_W-1:0]  mem [ctg_pkg::DEPTH];
  logic [ctg_pkg::VAL_W-1:0]  rd_a_q, rd_b_q;
  logic [ctg_pkg::ADDR_W-1:0] ra, rb, wa;
  logic                       wr_ok;

  logic [ctg_pkg::CNT_W-1:0]  n;
  logic [ctg_pkg::IDX_W-1:0]  e_idx;
  logic [ctg_pkg::IDX_W-1:0]  a_q, a_d, b_q, b_d, c_q, c_d;
  logic [ctg_pkg::IDX_W-1:0]  ab_q;
  logic [ctg_pkg::VAL_W-1:0]  lhs_q;
  logic                       id_ok_q, as_ok_q, inv_ok_q, bad_q;
  ctg_pkg::result_t           res_q;

  // order saturates at the store size
  assign n = (32'(order_i) > ctg_pkg::MAX_ORDER) ?
             ctg_pkg::CNT_W'(ctg_pkg::MAX_ORDER) : ctg_pkg::CNT_W'(order_i);
  assign e_idx = ctg_pkg::to_idx(ident_i);

  // entries outside the store are dropped
  assign wr_ok = wr_en_i && (32'(wr_row_i) < ctg_pkg::MAX_ORDER)
                         && (32'(wr_col_i) < ctg_pkg::MAX_ORDER);
  assign wa    = {ctg_pkg::to_idx(wr_row_i), ctg_pkg::to_idx(wr_col_i)};

  always_comb begin
    case (cmd_i.rd_sel)
      ctg_pkg::RD_AB: begin
        ra = {a_q, b_q};
        rb = {b_q, a_q};
      end
      ctg_pkg::RD_ID: begin
        ra = {e_idx, a_q};
        rb = {a_q, e_idx};
      end
      ctg_pkg::RD_BC: begin
        ra = {b_q, c_q};
        rb = {ab_q, c_q};
      end
      ctg_pkg::RD_A_BC: begin
        ra = {a_q, ctg_pkg::to_idx(rd_a_q)};
        rb = {a_q, b_q};
      end
      default: begin
        ra = {a_q, b_q};
        rb = {b_q, a_q};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wa] <= wr_val_i;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  // loop counters
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    case (cmd_i.cnt_op)
      ctg_pkg::CNT_CLR: begin
        a_d = '0;
        b_d = '0;
        c_d = '0;
      end
      ctg_pkg::CNT_STEP_A: begin
        a_d = ctg_pkg::IDX_W'(a_q + 1'b1);
        b_d = '0;
        c_d = '0;
      end
      ctg_pkg::CNT_STEP_B: begin
        if (sts_o.b_last) begin
          b_d = '0;
          a_d = ctg_pkg::IDX_W'(a_q + 1'b1);
        end else begin
          b_d = ctg_pkg::IDX_W'(b_q + 1'b1);
        end
      end
      ctg_pkg::CNT_STEP_C: begin
        if (!sts_o.c_last) begin
          c_d = ctg_pkg::IDX_W'(c_q + 1'b1);
        end else begin
          c_d = '0;
          if (sts_o.b_last) begin
            b_d = '0;
            a_d = ctg_pkg::IDX_W'(a_q + 1'b1);
          end else begin
            b_d = ctg_pkg::IDX_W'(b_q + 1'b1);
          end
        end
      end
      default: begin
        a_d = a_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q      <= '0;
      b_q      <= '0;
      c_q      <= '0;
      id_ok_q  <= 1'b1;
      as_ok_q  <= 1'b1;
      inv_ok_q <= 1'b1;
      bad_q    <= 1'b0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      if (cmd_i.flags_init) begin
        id_ok_q  <= 1'b1;
        as_ok_q  <= 1'b1;
        inv_ok_q <= 1'b1;
        bad_q    <= sts_o.e_bad;
      end else begin
        if (cmd_i.fail_range) bad_q    <= 1'b1;
        if (cmd_i.fail_id)    id_ok_q  <= 1'b0;
        if (cmd_i.fail_as)    as_ok_q  <= 1'b0;
        if (cmd_i.fail_inv)   inv_ok_q <= 1'b0;
      end
    end
  end

  // operand hold registers and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_ab) begin
      ab_q <= ctg_pkg::to_idx(rd_a_q);
    end
    if (cmd_i.ld_lhs) begin
      lhs_q <= rd_b_q;
    end
    if (cmd_i.ld_out) begin
      res_q.identity_pass <= id_ok_q  && !bad_q;
      res_q.assoc_pass    <= as_ok_q  && !bad_q;
      res_q.inverse_ok    <= inv_ok_q && !bad_q;
      res_q.range_ok      <= !bad_q;
    end
  end

  assign sts_o.e_bad       = 32'(ident_i) >= 32'(n);
  assign sts_o.range_fail  = 32'(rd_a_q) >= 32'(n);
  assign sts_o.id_mismatch = (32'(rd_a_q) != 32'(a_q)) || (32'(rd_b_q) != 32'(a_q));
  assign sts_o.as_mismatch = rd_a_q != lhs_q;
  assign sts_o.inv_hit     = (rd_a_q == ident_i) && (rd_b_q == ident_i);
  assign sts_o.a_last      = (32'(a_q) + 32'd1) == 32'(n);
  assign sts_o.b_last      = (32'(b_q) + 32'd1) == 32'(n);
  assign sts_o.c_last      = (32'(c_q) + 32'd1) == 32'(n);

  assign res_o = res_q;

`ifndef SYNTH
  // a range failure forces every verdict low
  a_bad_all_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_out && bad_q |=> res_q == '0)
    else $error("range failure did not clear all verdicts");

  // a check whose range held reports range_ok as a pass
  a_pass_needs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_out && !bad_q |=> res_q.range_ok)
    else $error("range verdict lost");

  // products used as indexes in the associativity sweep lie below n
  a_ab_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_ab |-> 32'(rd_a_q) < 32'(n))
    else $error("product index outside the checked square");
`endif

endmodule

@@ src/ctg_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctg_ctrl
// Controller: sequences table loading, the range, identity, associativity
// and inverse sweeps, and the result handshake.
// ----------------------------------------------------------------------------
module ctg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ctg_pkg::dp_sts_t  sts_i,
  output ctg_pkg::dp_cmd_t  cmd_o
);

  ctg_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.cnt_op = ctg_pkg::CNT_HOLD;
    cmd_o.rd_sel = ctg_pkg::RD_AB;

    case (state_q)
      ctg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && last_i) begin
          cmd_o.cnt_op     = ctg_pkg::CNT_CLR;
          cmd_o.flags_init = 1'b1;
          state_d = sts_i.e_bad ? ctg_pkg::ST_DONE : ctg_pkg::ST_RNG_RD;
        end
      end
      ctg_pkg::ST_RNG_RD: begin
        cmd_o.rd_sel = ctg_pkg::RD_AB;
        state_d      = ctg_pkg::ST_RNG_CHK;
      end
      ctg_pkg::ST_RNG_CHK: begin
        if (sts_i.range_fail) begin
          cmd_o.fail_range = 1'b1;
          state_d          = ctg_pkg::ST_DONE;
        end else if (sts_i.a_last && sts_i.b_last) begin
          cmd_o.cnt_op = ctg_pkg::CNT_CLR;
          state_d      = ctg_pkg::ST_ID_RD;
        end else begin
          cmd_o.cnt_op = ctg_pkg::CNT_STEP_B;
          state_d      = ctg_pkg::ST_RNG_RD;
        end
      end
      ctg_pkg::ST_ID_RD: begin
        cmd_o.rd_sel = ctg_pkg::RD_ID;
        state_d      = ctg_pkg::ST_ID_CHK;
      end
      ctg_pkg::ST_ID_CHK: begin
        cmd_o.fail_id = sts_i.id_mismatch;
        if (sts_i.id_mismatch || sts_i.a_last) begin
          cmd_o.cnt_op = ctg_pkg::CNT_CLR;
          state_d      = ctg_pkg::ST_AS_AB_RD;
        end else begin
          cmd_o.cnt_op = ctg_pkg::CNT_STEP_A;
          state_d      = ctg_pkg::ST_ID_RD;
        end
      end
      ctg_pkg::ST_AS_AB_RD: begin
        cmd_o.rd_sel = ctg_pkg::RD_AB;
        state_d      = ctg_pkg::ST_AS_AB_WT;
      end
      ctg_pkg::ST_AS_AB_WT: begin
        cmd_o.ld_ab = 1'b1;
        state_d     = ctg_pkg::ST_AS_C_RD;
      end
      ctg_pkg::ST_AS_C_RD: begin
        cmd_o.rd_sel = ctg_pkg::RD_BC;
        state_d      = ctg_pkg::ST_AS_C_WT;
      end
      ctg_pkg::ST_AS_C_WT: begin
        cmd_o.ld_lhs = 1'b1;
        cmd_o.rd_sel = ctg_pkg::RD_A_BC;
        state_d      = ctg_pkg::ST_AS_CMP;
      end
      ctg_pkg::ST_AS_CMP: begin
        if (sts_i.as_mismatch) begin
          cmd_o.fail_as = 1'b1;
          cmd_o.cnt_op  = ctg_pkg::CNT_CLR;
          state_d       = ctg_pkg::ST_INV_RD;
        end else if (sts_i.a_last && sts_i.b_last && sts_i.c_last) begin
          cmd_o.cnt_op = ctg_pkg::CNT_CLR;
          state_d      = ctg_pkg::ST_INV_RD;
        end else begin
          cmd_o.cnt_op = ctg_pkg::CNT_STEP_C;
          state_d      = sts_i.c_last ? ctg_pkg::ST_AS_AB_RD : ctg_pkg::ST_AS_C_RD;
        end
      end
      ctg_pkg::ST_INV_RD: begin
        cmd_o.rd_sel = ctg_pkg::RD_AB;
        state_d      = ctg_pkg::ST_INV_CHK;
      end
      ctg_pkg::ST_INV_CHK: begin
        if (sts_i.inv_hit) begin
          if (sts_i.a_last) begin
            state_d = ctg_pkg::ST_DONE;
          end else begin
            cmd_o.cnt_op = ctg_pkg::CNT_STEP_A;
            state_d      = ctg_pkg::ST_INV_RD;
          end
        end else if (sts_i.b_last) begin
          cmd_o.fail_inv = 1'b1;
          state_d        = ctg_pkg::ST_DONE;
        end else begin
          cmd_o.cnt_op = ctg_pkg::CNT_STEP_B;
          state_d      = ctg_pkg::ST_INV_RD;
        end
      end
      ctg_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ctg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ctg_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // a last entry always starts a check
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> state_q != ctg_pkg::ST_IDLE)
    else $error("last entry did not start a check");

  // a pending verdict is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ctg_pkg::ST_DONE && out_valid_q && !out_ready_i
      |=> state_q == ctg_pkg::ST_DONE)
    else $error("verdict overwritten while pending");

  // a new verdict only comes out of the done state
  a_verdict_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ctg_pkg::ST_DONE)
    else $error("verdict raised outside done state");
`endif

endmodule

@@ sim/tb_cayley_table_group_check.sv @@
// ----------------------------------------------------------------------------
// tb_cayley_table_group_check
// Self-checking bench for the Cayley table group check. A short list of
// hand-picked table loads comes first, then randomized phases that load real
// groups, monoids and scrambled tables under random order and identity settings.
// Every verdict beat is compared with a behavioral predictor or a pinned verdict.
// ----------------------------------------------------------------------------
module tb_cayley_table_group_check;
  timeunit 1ns;
  timeprecision 1ps;

  import ctg_pkg::*;

  // run shape
  localparam int ITEM_GOAL     = 1000;
  localparam int VERDICT_GOAL  = 48;
  localparam int HOLD_CYCLES   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 64;
  localparam int TIMEOUT_NS    = 6_000_000;
  localparam int VAL_TOP       = (1 << VAL_W) - 1;
  localparam int ORDER_TOP     = (1 << CFG_W) - 1;
  localparam int DIR_LEN       = 24;

  typedef enum logic {ROW_ENTRY, ROW_CFG} step_kind_e;

  // shapes of generated operation tables, in relabeled form
  typedef enum logic [2:0] {
    TK_CYCLIC,
    TK_XOR,
    TK_MAX,
    TK_LEFT,
    TK_CONST,
    TK_SCRAMBLE
  } table_kind_e;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_e;

  typedef struct packed {
    step_kind_e       kind;
    logic [VAL_W-1:0] row;
    logic [VAL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
    cfg_reg_e         reg_sel;
    logic [CFG_W-1:0] wdata;
    logic             typed;
    result_t          verdict;
  } dir_step_t;

  // verdict order: identity, assoc, inverse, range
  localparam result_t V_GROUP  = 4'b1111;
  localparam result_t V_MONOID = 4'b1101;
  localparam result_t V_BROKEN = 4'b0000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  ctg_entry_if  entry_bus ();
  ctg_result_if verdict_bus ();

  cayley_table_group_check u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (entry_bus),
    .result_o    (verdict_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state: mirrored table, config copy, expected verdicts
  // --------------------------------------------------------------------------
  logic [VAL_W-1:0] cayley_tab [MAX_ORDER][MAX_ORDER];
  logic [CFG_W-1:0] order_reg      = CFG_W'(1);
  logic [VAL_W-1:0] ident_reg      = '0;
  logic             range_err_flag = 1'b0;
  result_t          verdict_q [$];

  int unsigned mismatches    = 0;
  int unsigned verdicts_seen = 0;
  int unsigned items_sent    = 0;
  int unsigned burst_left    = 0;
  bit          gapless       = 1'b0;
  bit          hold_req      = 1'b0;

  // a directed row may pin its verdict; the monitor picks it up on acceptance
  bit          pin_verdict    = 1'b0;
  result_t     pinned_verdict = V_BROKEN;

  // directed loads, walked in order; config rows wait for the block to drain
  dir_step_t directed [DIR_LEN] = '{
    // order 1, identity 0: the one-element group
    '{ROW_ENTRY, 4'd0,  4'd0,  4'd0,  1'b1, CFG_GROUP_ORDER, 5'd0,  1'b1, V_GROUP},
    // largest value on order 1 is out of range
    '{ROW_ENTRY, 4'd0,  4'd0,  4'd15, 1'b1, CFG_GROUP_ORDER, 5'd0,  1'b1, V_BROKEN},
    // order zero: identity can never be below n
    '{ROW_CFG,   4'd0,  4'd0,  4'd0,  1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd0,  4'd0,  4'd0,  1'b1, CFG_GROUP_ORDER, 5'd0,  1'b1, V_BROKEN},
    // Z2 with identity 1
    '{ROW_CFG,   4'd0,  4'd0,  4'd0,  1'b0, CFG_GROUP_ORDER, 5'd2,  1'b0, V_BROKEN},
    '{ROW_CFG,   4'd0,  4'd0,  4'd0,  1'b0, CFG_IDENTITY,    5'd1,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd0,  4'd0,  4'd1,  1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd0,  4'd1,  4'd0,  1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd1,  4'd0,  4'd0,  1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd1,  4'd1,  4'd1,  1'b1, CFG_GROUP_ORDER, 5'd0,  1'b1, V_GROUP},
    // identity at its largest code, far above n
    '{ROW_CFG,   4'd0,  4'd0,  4'd0,  1'b0, CFG_IDENTITY,    5'd15, 1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd1,  4'd1,  4'd1,  1'b1, CFG_GROUP_ORDER, 5'd0,  1'b1, V_BROKEN},
    // max monoid: identity and assoc hold, 1 has no inverse
    '{ROW_CFG,   4'd0,  4'd0,  4'd0,  1'b0, CFG_IDENTITY,    5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd0,  4'd0,  4'd0,  1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd0,  4'd1,  4'd1,  1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd1,  4'd0,  4'd1,  1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd1,  4'd1,  4'd1,  1'b1, CFG_GROUP_ORDER, 5'd0,  1'b1, V_MONOID},
    // one rewrite turns it into xor on two elements
    '{ROW_ENTRY, 4'd1,  4'd1,  4'd0,  1'b1, CFG_GROUP_ORDER, 5'd0,  1'b1, V_GROUP},
    // corners of the table, outside the checked square
    '{ROW_ENTRY, 4'd15, 4'd15, 4'd15, 1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd15, 4'd0,  4'd0,  1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    '{ROW_ENTRY, 4'd0,  4'd15, 4'd15, 1'b0, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    // last mark on an entry outside the square still runs a check
    '{ROW_ENTRY, 4'd9,  4'd6,  4'd10, 1'b1, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    // left identity broken
    '{ROW_ENTRY, 4'd0,  4'd1,  4'd0,  1'b1, CFG_GROUP_ORDER, 5'd0,  1'b0, V_BROKEN},
    // value equal to n inside the square
    '{ROW_ENTRY, 4'd1,  4'd0,  4'd2,  1'b1, CFG_GROUP_ORDER, 5'd0,  1'b1, V_BROKEN}
  };

  // --------------------------------------------------------------------------
  // predictor: verdict of the mirrored table under the mirrored config
  // --------------------------------------------------------------------------
  function automatic result_t group_verdict();
    int unsigned n, e, a, b, c;
    bit          bad, found;
    result_t     v;
    n = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
    e = ident_reg;
    v = V_BROKEN;
    bad = (e >= n);
    for (a = 0; a < n; a++)
      for (b = 0; b < n; b++)
        if (cayley_tab[a][b] >= n) bad = 1'b1;
    if (!bad) begin
      v.identity_pass = 1'b1;
      for (a = 0; a < n; a++)
        if (cayley_tab[e][a] != a || cayley_tab[a][e] != a) v.identity_pass = 1'b0;
      // every value is below n here, so products index the table directly
      v.assoc_pass = 1'b1;
      for (a = 0; a < n; a++)
        for (b = 0; b < n; b++)
          for (c = 0; c < n; c++)
            if (cayley_tab[cayley_tab[a][b]][c] != cayley_tab[a][cayley_tab[b][c]])
              v.assoc_pass = 1'b0;
      v.inverse_ok = 1'b1;
      for (a = 0; a < n; a++) begin
        found = 1'b0;
        for (b = 0; b < n; b++)
          if (cayley_tab[a][b] == e && cayley_tab[b][a] == e) found = 1'b1;
        if (!found) v.inverse_ok = 1'b0;
      end
    end
    v.range_ok = !bad;
    return v;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    $display("verdict error @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t got, want;
    if (rst_ni) begin
      // config copy follows the write port exactly as the block sees it
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_GROUP_ORDER: order_reg = cfg_wdata_i;
          CFG_IDENTITY:    ident_reg = cfg_wdata_i[VAL_W-1:0];
          default: ;
        endcase
      end
      // accepted entry beat: store, then check if marked last
      if (entry_bus.valid && entry_bus.ready) begin
        cayley_tab[entry_bus.entry_row][entry_bus.entry_col] = entry_bus.entry_value;
        if (entry_bus.last_entry) begin
          want = group_verdict();
          range_err_flag = !want.range_ok;
          if (pin_verdict) want = pinned_verdict;
          verdict_q = {verdict_q, want};
        end
      end
      // accepted verdict beat: compare against the oldest expectation
      if (verdict_bus.valid && verdict_bus.ready) begin
        verdicts_seen++;
        got.identity_pass = verdict_bus.identity_pass;
        got.assoc_pass    = verdict_bus.assoc_pass;
        got.inverse_ok    = verdict_bus.inverse_ok;
        got.range_ok      = verdict_bus.range_ok;
        if (verdict_q.size() == 0) begin
          note_mismatch($sformatf("verdict %b with none outstanding", got));
        end else begin
          want = verdict_q.pop_front();
          if (got.identity_pass !== want.identity_pass)
            note_mismatch($sformatf("identity_pass %b, want %b", got.identity_pass,
                                    want.identity_pass));
          if (got.assoc_pass !== want.assoc_pass)
            note_mismatch($sformatf("assoc_pass %b, want %b", got.assoc_pass,
                                    want.assoc_pass));
          if (got.inverse_ok !== want.inverse_ok)
            note_mismatch($sformatf("inverse_ok %b, want %b", got.inverse_ok,
                                    want.inverse_ok));
          if (got.range_ok !== want.range_ok)
            note_mismatch($sformatf("range_ok %b, want %b", got.range_ok, want.range_ok));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // verdict sink: stall pattern of its own, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : verdict_sink
    sink_mode_e  mode;
    int unsigned mode_left, held;
    verdict_bus.ready <= 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    held      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // long hold: the block fills its output register and stalls entries
        verdict_bus.ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) begin
          hold_req = 1'b0;
          held     = 0;
        end
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   verdict_bus.ready <= 1'b1;
          SINK_COIN:   verdict_bus.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: verdict_bus.ready <= ($urandom_range(0, 3) == 0);
          default:     verdict_bus.ready <= (mode_left % 5 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // entry source
  // --------------------------------------------------------------------------

  // one entry beat; bursts of random length with random gaps in between
  task automatic send_entry(logic [VAL_W-1:0] row, logic [VAL_W-1:0] col,
                            logic [VAL_W-1:0] value, logic last,
                            bit pin, result_t pinned);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gapless ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk_i);
        entry_bus.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    entry_bus.valid       <= 1'b1;
    entry_bus.entry_row   <= row;
    entry_bus.entry_col   <= col;
    entry_bus.entry_value <= value;
    entry_bus.last_entry  <= last;
    pin_verdict    = pin;
    pinned_verdict = pinned;
    do @(posedge clk_i); while (entry_bus.ready !== 1'b1);
    items_sent++;
  endtask

  // stray write anywhere in the table
  task automatic send_noise(logic last);
    send_entry(VAL_W'($urandom_range(0, VAL_TOP)), VAL_W'($urandom_range(0, VAL_TOP)),
               VAL_W'($urandom_range(0, VAL_TOP)), last, 1'b0, V_BROKEN);
  endtask

  // stop offering, wait for every verdict, then let stray stores settle
  task automatic quiesce();
    @(negedge clk_i);
    entry_bus.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // one settings phase: configure, then load and check several tables
  task automatic run_phase(logic [CFG_W-1:0] order_raw, int unsigned checks,
                           bit long_hold);
    int unsigned      perm  [MAX_ORDER];
    int unsigned      slots [MAX_ORDER*MAX_ORDER];
    logic [VAL_W-1:0] tab   [MAX_ORDER][MAX_ORDER];
    int unsigned      n, chk, k, j, tmp, x, y, lv, cval, cnt, pick;
    logic [VAL_W-1:0] ident;
    table_kind_e      kind;
    bit               partial, last_on_noise;
    n = (order_raw > MAX_ORDER) ? MAX_ORDER : order_raw;
    quiesce();
    // random relabeling so identities and structure land anywhere
    for (k = 0; k < MAX_ORDER; k++) perm[k] = k;
    for (k = n; k > 1; k--) begin
      j = $urandom_range(0, k - 1);
      tmp = perm[k-1]; perm[k-1] = perm[j]; perm[j] = tmp;
    end
    // mostly the true identity of the relabeled table, sometimes anything
    if (n > 0 && $urandom_range(0, 4) != 0) ident = VAL_W'(perm[0]);
    else ident = VAL_W'($urandom_range(0, VAL_TOP));
    write_reg(CFG_GROUP_ORDER, order_raw);
    write_reg(CFG_IDENTITY, CFG_W'(ident));
    if (long_hold) hold_req = 1'b1;
    gapless = ($urandom_range(0, 3) == 0);

    for (chk = 0; chk < checks; chk++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      kind = TK_CYCLIC;
      else if (pick < 50) kind = TK_XOR;
      else if (pick < 65) kind = TK_MAX;
      else if (pick < 75) kind = TK_LEFT;
      else if (pick < 85) kind = TK_CONST;
      else                kind = TK_SCRAMBLE;
      cval = (n > 0) ? $urandom_range(0, n - 1) : 0;
      for (x = 0; x < n; x++)
        for (y = 0; y < n; y++) begin
          case (kind)
            TK_CYCLIC: lv = (x + y) % n;
            TK_XOR:    lv = ((n & (n - 1)) == 0) ? (x ^ y) : (x + y) % n;
            TK_MAX:    lv = (x > y) ? x : y;
            TK_LEFT:   lv = x;
            TK_CONST:  lv = cval;
            default:   lv = $urandom_range(0, n - 1);
          endcase
          tab[perm[x]][perm[y]] = VAL_W'(perm[lv]);
        end
      // single corrupted product: may break an axiom or the range
      if (n > 0 && $urandom_range(0, 3) == 0)
        tab[$urandom_range(0, n - 1)][$urandom_range(0, n - 1)] =
          VAL_W'($urandom_range(0, VAL_TOP));

      cnt = n * n;
      for (k = 0; k < cnt; k++) slots[k] = (k / n) * MAX_ORDER + (k % n);
      if ($urandom_range(0, 1)) begin
        for (k = cnt; k > 1; k--) begin
          j = $urandom_range(0, k - 1);
          tmp = slots[k-1]; slots[k-1] = slots[j]; slots[j] = tmp;
        end
      end
      // a first load in a phase is always complete; later ones may rewrite
      // only part of the table, the rest keeps its old contents
      partial       = (chk > 0) && ($urandom_range(0, 2) == 0);
      last_on_noise = (n == 0) || ($urandom_range(0, 6) == 0);
      for (k = 0; k < cnt; k++) begin
        if ($urandom_range(0, 19) == 0) send_noise(1'b0);
        if (!(partial && k != cnt - 1 && $urandom_range(0, 1))) begin
          x = slots[k] / MAX_ORDER;
          y = slots[k] % MAX_ORDER;
          send_entry(VAL_W'(x), VAL_W'(y), tab[x][y],
                     !last_on_noise && (k == cnt - 1), 1'b0, V_BROKEN);
        end
      end
      if (last_on_noise) send_noise(1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k, pick, phase, wide_phases;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_GROUP_ORDER;
    cfg_wdata_i           <= '0;
    entry_bus.valid       <= 1'b0;
    entry_bus.entry_row   <= '0;
    entry_bus.entry_col   <= '0;
    entry_bus.entry_value <= '0;
    entry_bus.last_entry  <= 1'b0;
    phase       = 0;
    wide_phases = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed loads; only the small squares they touch are ever checked
    for (k = 0; k < DIR_LEN; k++) begin
      if (directed[k].kind == ROW_CFG) begin
        quiesce();
        write_reg(directed[k].reg_sel, directed[k].wdata);
      end else begin
        send_entry(directed[k].row, directed[k].col, directed[k].value, directed[k].last,
                   directed[k].typed, directed[k].verdict);
      end
    end

    // full 16x16 load at the top order code; every entry is defined after it
    run_phase(CFG_W'(ORDER_TOP), 1, 1'b0);

    // mostly small orders, a few mid-size, rare order zero and full size
    while (items_sent < ITEM_GOAL || verdicts_seen < VERDICT_GOAL) begin
      pick = $urandom_range(0, 99);
      if (phase == 2) begin
        // back-to-back checks against a sink that holds off for a long time
        run_phase(CFG_W'(3), 4, 1'b1);
      end else if (pick < 3) begin
        run_phase('0, $urandom_range(1, 3), 1'b0);
      end else if (pick < 6 && wide_phases < 2) begin
        wide_phases++;
        run_phase(CFG_W'($urandom_range(MAX_ORDER, ORDER_TOP)), 1, 1'b0);
      end else if (pick < 25) begin
        run_phase(CFG_W'($urandom_range(6, 8)), $urandom_range(1, 4), 1'b0);
      end else begin
        run_phase(CFG_W'($urandom_range(1, 5)), $urandom_range(1, 4), 1'b0);
      end
      phase++;
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop if the block hangs or a verdict never shows up
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
src/ctg_pkg.sv
src/ctg_ifs.sv
src/ctg_dp.sv
src/ctg_ctrl.sv
src/cayley_table_group_check.sv
sim/tb_cayley_table_group_check.sv
